// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int ADDR_BITS    = 48;
	localparam int SIZE_BITS    = 32;
	localparam int HEADER_BYTES = 32;
	localparam int ALIGN_BYTES  = 16;
	localparam int MIN_SPLIT    = 16;

	localparam logic [1:0] KIND_MALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE    = 2'd1;
	localparam logic [1:0] KIND_REALLOC = 2'd2;
	localparam logic [1:0] KIND_CALLOC  = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_FAIL    = 2'd1;
	localparam logic [1:0] STAT_IGNORED = 2'd2;

	localparam logic CFG_HEAP_BASE  = 1'b0;
	localparam logic CFG_HEAP_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]           kind;
		logic [ADDR_BITS-1:0] address;
		logic [SIZE_BITS-1:0] size;
		logic [SIZE_BITS-1:0] count;
	} req_t;

	typedef struct packed {
		logic [1:0]           status;
		logic [ADDR_BITS-1:0] result_address;
		logic [SIZE_BITS-1:0] copy_length;
		logic [SIZE_BITS-1:0] clear_length;
	} rsp_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] start;
		logic [SIZE_BITS-1:0] bytes;
		logic                 free;
	} ent_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MUL, S_PREP,
		S_FRD, S_FCK,
		S_MRD, S_MCK, S_APP,
		S_SP0, S_SPN,
		S_ORD, S_OWR, S_CRD, S_CWR,
		S_F0, S_F1, S_F2, S_F3, S_F5,
		S_R0, S_R1,
		S_FIN
	} fsm_t;

endpackage

// ===== rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ffha_ram #(
	parameter int WIDTH = 81,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/first_fit_heap_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit heap allocator with split, coalescing and break management.
// ----------------------------------------------------------------------------
// A request (malloc, free, realloc, calloc) is a transaction on req, taken
// when start is high and busy is low. busy stays high while a small sequencer
// walks the block table, which sits in one RAM with a registered read port.
// Every request gives exactly one response: done pulses for one cycle with
// rsp valid, and the receiver cannot hold it off. busy drops in that cycle.
// Each table entry visited by a search, insert or remove takes a read step,
// then a use step. The worst case is a realloc that moves its block: two
// searches for the old block, a first-fit pass, a slot insert and up to two
// table compactions.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write heap_base (0)
// or heap_limit (1); cfg_ready is always high. Write only while idle.
// Writing heap_base while the table is empty also moves the break.
// Reset: table empty, break at heap_base 0, heap_limit 1 MiB. The table RAM
// needs no clearing, entries at or above the block count are never used.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_core
	import ffha_pkg::*;
#(
	parameter int MAX_BLOCKS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_t                 req,
	output logic                 done,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [ADDR_BITS-1:0] cfg_data
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int TW = $clog2(MAX_BLOCKS + 1);
	localparam int EW = $bits(ent_t);

	fsm_t state_q, state_d, ret_q, ret_d;
	req_t req_q, req_d;
	logic [63:0] prod_q, prod_d;
	logic [SIZE_BITS-1:0] want_q, want_d, old_q, old_d;
	logic [TW-1:0] tot_q, tot_d, idx_q, idx_d, j_q, j_d;
	logic [ADDR_BITS-1:0] brk_q, brk_d, base_q, base_d, limit_q, limit_d;
	ent_t cur_q, cur_d, nw_q, nw_d;
	logic mv_q, mv_d;
	logic [1:0] st_q, st_d;
	logic [ADDR_BITS-1:0] ra_q, ra_d;
	logic [SIZE_BITS-1:0] cp_q, cp_d;
	logic done_q;
	rsp_t rsp_q, rsp_d;

	logic we;
	logic [IW-1:0] waddr, raddr;
	ent_t wdata, rd;
	logic [EW-1:0] rdata_raw;

	logic [SIZE_BITS-1:0] src;
	logic [SIZE_BITS:0] rnd;
	logic rok;
	logic [SIZE_BITS+1:0] joined;
	logic [ADDR_BITS:0] grow;
	logic split;

	ffha_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rd = ent_t'(rdata_raw);
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign rsp = rsp_q;

	// shared datapath terms
	always_comb begin
		src = (req_q.kind == KIND_CALLOC) ? prod_q[SIZE_BITS-1:0] : req_q.size;
		rnd = ({1'b0, src} + (SIZE_BITS+1)'(ALIGN_BYTES - 1))
			& ~(SIZE_BITS+1)'(ALIGN_BYTES - 1);
		rok = (src != '0) && !rnd[SIZE_BITS]
			&& !((req_q.kind == KIND_CALLOC) && (prod_q[63:SIZE_BITS] != '0));
		joined = {2'b0, cur_q.bytes} + (SIZE_BITS+2)'(HEADER_BYTES) + {2'b0, rd.bytes};
		grow = {1'b0, brk_q} + (ADDR_BITS+1)'(HEADER_BYTES) + (ADDR_BITS+1)'(want_q);
		split = (tot_q < TW'(MAX_BLOCKS)) && ({2'b0, cur_q.bytes} >= ({2'b0, want_q}
			+ (SIZE_BITS+2)'(HEADER_BYTES) + (SIZE_BITS+2)'(MIN_SPLIT)));
	end

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		req_d   = req_q;
		prod_d  = prod_q;
		want_d  = want_q;
		old_d   = old_q;
		tot_d   = tot_q;
		idx_d   = idx_q;
		j_d     = j_q;
		brk_d   = brk_q;
		base_d  = base_q;
		limit_d = limit_q;
		cur_d   = cur_q;
		nw_d    = nw_q;
		mv_d    = mv_q;
		st_d    = st_q;
		ra_d    = ra_q;
		cp_d    = cp_q;
		rsp_d   = rsp_q;
		we      = 1'b0;
		waddr   = idx_q[IW-1:0];
		wdata   = cur_q;
		raddr   = j_q[IW-1:0];

		case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d = req;
					st_d  = STAT_FAIL;
					ra_d  = '0;
					cp_d  = '0;
					mv_d  = 1'b0;
					state_d = (req.kind == KIND_CALLOC) ? S_MUL : S_PREP;
				end
			end
			S_MUL: begin
				prod_d  = {32'b0, req_q.count} * {32'b0, req_q.size};
				state_d = S_PREP;
			end
			S_PREP: begin
				want_d = rnd[SIZE_BITS-1:0];
				j_d    = '0;
				if (req_q.kind == KIND_FREE) begin
					state_d = S_FRD;
				end else if (req_q.kind == KIND_REALLOC && req_q.address != '0) begin
					if (req_q.size == '0 || rok) begin
						state_d = S_FRD;
					end else begin
						state_d = S_FIN;
					end
				end else begin
					state_d = rok ? S_MRD : S_FIN;
				end
			end
			// search for the block whose payload is at the request address
			S_FRD: begin
				if (req_q.address == '0 || j_q >= tot_q) begin
					if (req_q.kind == KIND_FREE) begin
						st_d = STAT_IGNORED;
					end
					state_d = S_FIN;
				end else begin
					state_d = S_FCK;
				end
			end
			S_FCK: begin
				if (rd.start + ADDR_BITS'(HEADER_BYTES) == req_q.address) begin
					idx_d = j_q;
					cur_d = rd;
					if (rd.free) begin
						if (req_q.kind == KIND_FREE) begin
							st_d = STAT_IGNORED;
						end
						state_d = S_FIN;
					end else if (mv_q) begin
						state_d = S_F0;
					end else if (req_q.kind == KIND_FREE) begin
						st_d = STAT_OK;
						state_d = S_F0;
					end else if (req_q.size == '0) begin
						state_d = S_F0;
					end else begin
						state_d = S_R0;
					end
				end else begin
					j_d = j_q + TW'(1);
					state_d = S_FRD;
				end
			end
			// first-fit pass
			S_MRD: begin
				state_d = (j_q >= tot_q) ? S_APP : S_MCK;
			end
			S_MCK: begin
				if (rd.free && rd.bytes >= want_q) begin
					idx_d = j_q;
					cur_d = rd;
					st_d  = STAT_OK;
					ra_d  = rd.start + ADDR_BITS'(HEADER_BYTES);
					cp_d  = mv_q ? old_q : '0;
					state_d = S_SP0;
				end else begin
					j_d = j_q + TW'(1);
					state_d = S_MRD;
				end
			end
			S_APP: begin
				if (tot_q >= TW'(MAX_BLOCKS) || grow[ADDR_BITS]
					|| grow[ADDR_BITS-1:0] > limit_q) begin
					state_d = S_FIN;
				end else begin
					we    = 1'b1;
					waddr = tot_q[IW-1:0];
					wdata = '{start: brk_q, bytes: want_q, free: 1'b0};
					tot_d = tot_q + TW'(1);
					brk_d = grow[ADDR_BITS-1:0];
					st_d  = STAT_OK;
					ra_d  = brk_q + ADDR_BITS'(HEADER_BYTES);
					cp_d  = mv_q ? old_q : '0;
					j_d   = '0;
					state_d = mv_q ? S_FRD : S_FIN;
				end
			end
			// split the chosen block and mark it in use
			S_SP0: begin
				we    = 1'b1;
				wdata = '{start: cur_q.start, bytes: split ? want_q : cur_q.bytes,
					free: 1'b0};
				nw_d  = '{start: cur_q.start + ADDR_BITS'(HEADER_BYTES) + ADDR_BITS'(want_q),
					bytes: cur_q.bytes - want_q - SIZE_BITS'(HEADER_BYTES), free: 1'b1};
				j_d = '0;
				if (split) begin
					j_d   = tot_q;
					ret_d = S_SPN;
					state_d = S_ORD;
				end else begin
					state_d = mv_q ? S_FRD : S_FIN;
				end
			end
			S_SPN: begin
				we    = 1'b1;
				waddr = IW'(idx_q + TW'(1));
				wdata = nw_q;
				j_d   = '0;
				state_d = mv_q ? S_FRD : S_FIN;
			end
			// open a slot at idx+1, moving entries up from the top
			S_ORD: begin
				if (j_q <= idx_q + TW'(1)) begin
					tot_d = tot_q + TW'(1);
					state_d = ret_q;
				end else begin
					raddr = IW'(j_q - TW'(1));
					state_d = S_OWR;
				end
			end
			S_OWR: begin
				we    = 1'b1;
				waddr = j_q[IW-1:0];
				wdata = rd;
				j_d   = j_q - TW'(1);
				state_d = S_ORD;
			end
			// close the slot below j, moving entries down
			S_CRD: begin
				if (j_q >= tot_q) begin
					tot_d = tot_q - TW'(1);
					state_d = ret_q;
				end else begin
					state_d = S_CWR;
				end
			end
			S_CWR: begin
				we    = 1'b1;
				waddr = IW'(j_q - TW'(1));
				wdata = rd;
				j_d   = j_q + TW'(1);
				state_d = S_CRD;
			end
			// release a block, merge with free neighbors, trim the break
			S_F0: begin
				cur_d.free = 1'b1;
				raddr = IW'(idx_q + TW'(1));
				state_d = (idx_q + TW'(1) < tot_q) ? S_F1 : S_F2;
			end
			S_F1: begin
				if (rd.free && joined[SIZE_BITS+1:SIZE_BITS] == 2'b0) begin
					cur_d.bytes = joined[SIZE_BITS-1:0];
					j_d   = idx_q + TW'(2);
					ret_d = S_F2;
					state_d = S_CRD;
				end else begin
					state_d = S_F2;
				end
			end
			S_F2: begin
				raddr = IW'(idx_q - TW'(1));
				state_d = (idx_q != '0) ? S_F3 : S_F5;
			end
			S_F3: begin
				if (rd.free && joined[SIZE_BITS+1:SIZE_BITS] == 2'b0) begin
					cur_d = '{start: rd.start, bytes: joined[SIZE_BITS-1:0], free: 1'b1};
					idx_d = idx_q - TW'(1);
					j_d   = idx_q + TW'(1);
					ret_d = S_F5;
					state_d = S_CRD;
				end else if (rd.free) begin
					// free neighbor below that cannot absorb it: the break stays put
					we = 1'b1;
					state_d = S_FIN;
				end else begin
					state_d = S_F5;
				end
			end
			S_F5: begin
				if (idx_q + TW'(1) == tot_q) begin
					brk_d = cur_q.start;
					tot_d = tot_q - TW'(1);
				end else begin
					we = 1'b1;
				end
				state_d = S_FIN;
			end
			// realloc of a live block: shrink, grow into free neighbor, or move
			S_R0: begin
				raddr = IW'(idx_q + TW'(1));
				if (cur_q.bytes >= want_q) begin
					st_d = STAT_OK;
					ra_d = req_q.address;
					state_d = S_SP0;
				end else if (idx_q + TW'(1) < tot_q) begin
					state_d = S_R1;
				end else begin
					mv_d  = 1'b1;
					old_d = cur_q.bytes;
					j_d   = '0;
					state_d = S_MRD;
				end
			end
			S_R1: begin
				if (rd.free && joined >= {2'b0, want_q}
					&& joined[SIZE_BITS+1:SIZE_BITS] == 2'b0) begin
					cur_d.bytes = joined[SIZE_BITS-1:0];
					st_d  = STAT_OK;
					ra_d  = req_q.address;
					j_d   = idx_q + TW'(2);
					ret_d = S_SP0;
					state_d = S_CRD;
				end else begin
					mv_d  = 1'b1;
					old_d = cur_q.bytes;
					j_d   = '0;
					state_d = S_MRD;
				end
			end
			S_FIN: begin
				rsp_d.status         = st_q;
				rsp_d.result_address = (st_q == STAT_OK) ? ra_q : '0;
				rsp_d.copy_length    = (st_q == STAT_OK) ? cp_q : '0;
				rsp_d.clear_length   = (st_q == STAT_OK && req_q.kind == KIND_CALLOC)
					? prod_q[SIZE_BITS-1:0] : '0;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (cfg_valid) begin
			if (cfg_index == CFG_HEAP_BASE) begin
				base_d = cfg_data;
				if (tot_q == '0) begin
					brk_d = cfg_data;
				end
			end else begin
				limit_d = cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			tot_q   <= '0;
			brk_q   <= '0;
			base_q  <= '0;
			limit_q <= ADDR_BITS'(1048576);
			mv_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			tot_q   <= tot_d;
			brk_q   <= brk_d;
			base_q  <= base_d;
			limit_q <= limit_d;
			mv_q    <= mv_d;
			done_q  <= (state_q == S_FIN);
		end
	end

	always_ff @(posedge clk) begin
		req_q  <= req_d;
		prod_q <= prod_d;
		want_q <= want_d;
		old_q  <= old_d;
		idx_q  <= idx_d;
		j_q    <= j_d;
		cur_q  <= cur_d;
		nw_q   <= nw_d;
		st_q   <= st_d;
		ra_q   <= ra_d;
		cp_q   <= cp_d;
		rsp_q  <= rsp_d;
	end

	a_tot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tot_q <= TW'(MAX_BLOCKS))
		else $error("block count above table size");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == S_FIN))
		else $error("response strobe without finishing step");

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q != S_IDLE))
		else $error("table write while idle");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction taken but sequencer not started");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit heap allocator core. Directed
// requests hit the corner cases of malloc, free, realloc and calloc, then
// random request streams run under several heap base/limit settings. A
// scoreboard keeps its own copy of the block table and break, predicts each
// response and compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module tb;
	import ffha_pkg::*;

	localparam logic [63:0] ADDR_MASK  = 64'hFFFF_FFFF_FFFF;
	localparam logic [63:0] SIZE_TOP   = 64'hFFFF_FFFF;
	localparam int          TABLE_SIZE = 64;
	localparam int          CYCLE_LIMIT = 12_000_000;

	class heap_scoreboard;
		logic [47:0] heap_base, heap_lim, brk;
		logic [47:0] st[TABLE_SIZE];
		logic [31:0] by[TABLE_SIZE];
		bit          fr[TABLE_SIZE];
		int          used;
		rsp_t        pending[$];
		logic [47:0] last_addr;
		int          errors;
		int          checked;

		function new();
			heap_base = '0;
			heap_lim  = 48'd1048576;
			brk       = '0;
			used      = 0;
			errors    = 0;
			checked   = 0;
		endfunction

		task report(string msg);
			$display("tb: mismatch: %s", msg);
			errors++;
		endtask

		function void set_reg(logic idx, logic [47:0] v);
			if (idx == CFG_HEAP_BASE) begin
				heap_base = v;
				if (used == 0)
					brk = v;
			end else begin
				heap_lim = v;
			end
		endfunction

		function bit round_up(logic [63:0] n, output logic [31:0] r);
			logic [63:0] t;
			r = '0;
			if (n == 0 || n > SIZE_TOP)
				return 0;
			t = (n + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
			if (t > SIZE_TOP)
				return 0;
			r = t[31:0];
			return 1;
		endfunction

		function void open_slot(int i);
			for (int j = used; j > i; j--) begin
				st[j] = st[j-1];
				by[j] = by[j-1];
				fr[j] = fr[j-1];
			end
			used++;
		endfunction

		function void close_slot(int i);
			for (int j = i; j < used - 1; j++) begin
				st[j] = st[j+1];
				by[j] = by[j+1];
				fr[j] = fr[j+1];
			end
			used--;
		endfunction

		function void split(int i, logic [31:0] want);
			logic [63:0] have;
			have = by[i];
			if (used >= TABLE_SIZE)
				return;
			if (have < 64'(want) + HEADER_BYTES + MIN_SPLIT)
				return;
			open_slot(i + 1);
			st[i+1] = 48'((64'(st[i]) + HEADER_BYTES + want) & ADDR_MASK);
			by[i+1] = 32'(have - want - HEADER_BYTES);
			fr[i+1] = 1;
			by[i]   = want;
		endfunction

		function logic [63:0] joined(int i);
			return 64'(by[i]) + HEADER_BYTES + 64'(by[i+1]);
		endfunction

		function void merge_next(int i);
			if (i + 1 >= used || !fr[i+1])
				return;
			if (joined(i) > SIZE_TOP)
				return;
			by[i] = 32'(joined(i));
			close_slot(i + 1);
		endfunction

		function int locate(logic [47:0] a);
			if (a == 0)
				return -1;
			for (int i = 0; i < used; i++)
				if (48'(64'(st[i]) + HEADER_BYTES) == a)
					return i;
			return -1;
		endfunction

		function bit allocate(logic [63:0] n, output logic [63:0] a);
			logic [31:0] want;
			logic [63:0] grow;
			a = '0;
			if (!round_up(n, want))
				return 0;
			for (int i = 0; i < used; i++) begin
				if (fr[i] && by[i] >= want) begin
					split(i, want);
					fr[i] = 0;
					a = (64'(st[i]) + HEADER_BYTES) & ADDR_MASK;
					return 1;
				end
			end
			if (used >= TABLE_SIZE)
				return 0;
			grow = 64'(HEADER_BYTES) + want;
			if (grow > ADDR_MASK - 64'(brk))
				return 0;
			if (64'(brk) + grow > 64'(heap_lim))
				return 0;
			st[used] = brk;
			by[used] = want;
			fr[used] = 0;
			a = (64'(brk) + HEADER_BYTES) & ADDR_MASK;
			used++;
			brk = 48'(64'(brk) + grow);
			return 1;
		endfunction

		function void release_block(int i);
			fr[i] = 1;
			merge_next(i);
			if (i > 0 && fr[i-1]) begin
				i--;
				merge_next(i);
			end
			if (i + 1 == used) begin
				brk = st[i];
				close_slot(i);
			end
		endfunction

		function int first_busy();
			for (int i = 0; i < used; i++)
				if (!fr[i])
					return i;
			return -1;
		endfunction

		function void note_request(req_t q);
			rsp_t        r;
			logic [63:0] res, moved, prod, old;
			logic [31:0] want;
			int          idx;
			r = '0;
			res = '0;
			r.status = STAT_FAIL;
			case (q.kind)
				KIND_MALLOC: begin
					if (allocate(64'(q.size), res))
						r.status = STAT_OK;
				end
				KIND_FREE: begin
					idx = locate(q.address);
					if (idx < 0 || fr[idx]) begin
						r.status = STAT_IGNORED;
					end else begin
						release_block(idx);
						r.status = STAT_OK;
					end
				end
				KIND_REALLOC: begin
					if (q.address == 0) begin
						if (allocate(64'(q.size), res))
							r.status = STAT_OK;
					end else if (q.size == 0) begin
						idx = locate(q.address);
						if (idx >= 0 && !fr[idx])
							release_block(idx);
					end else begin
						idx = locate(q.address);
						if (round_up(64'(q.size), want) && idx >= 0 && !fr[idx]) begin
							if (by[idx] >= want) begin
								split(idx, want);
								res = 64'(q.address);
								r.status = STAT_OK;
							end else if (idx + 1 < used && fr[idx+1] && joined(idx) >= want
									&& joined(idx) <= SIZE_TOP) begin
								merge_next(idx);
								split(idx, want);
								fr[idx] = 0;
								res = 64'(q.address);
								r.status = STAT_OK;
							end else begin
								old = by[idx];
								if (allocate(64'(q.size), moved)) begin
									idx = locate(q.address);
									if (idx >= 0)
										release_block(idx);
									res = moved;
									r.copy_length = old[31:0];
									r.status = STAT_OK;
								end
							end
						end
					end
				end
				default: begin
					prod = 64'(q.count) * 64'(q.size);
					if (prod <= SIZE_TOP && allocate(prod, res)) begin
						r.clear_length = prod[31:0];
						r.status = STAT_OK;
					end
				end
			endcase
			if (r.status != STAT_OK)
				res = '0;
			r.result_address = res[47:0];
			last_addr = res[47:0];
			pending.push_back(r);
		endfunction

		task check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				report($sformatf("response with nothing outstanding: %h", got));
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.result_address !== want.result_address)
				report($sformatf("result_address %h, expected %h",
					got.result_address, want.result_address));
			if (got.copy_length !== want.copy_length)
				report($sformatf("copy_length %0d, expected %0d",
					got.copy_length, want.copy_length));
			if (got.clear_length !== want.clear_length)
				report($sformatf("clear_length %0d, expected %0d",
					got.clear_length, want.clear_length));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	req_t                 req;
	logic                 done;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic                 cfg_index;
	logic [ADDR_BITS-1:0] cfg_data;

	heap_scoreboard sb = new();
	int             idle_pct;
	int             sent;
	int             cycles;

	first_fit_heap_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_response(rsp);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycles);
			$display("tb: FAIL");
			$finish;
		end
	end

	task automatic send(logic [1:0] kind, logic [47:0] a, logic [31:0] size,
			logic [31:0] count);
		req_t r;
		r.kind    = kind;
		r.address = a;
		r.size    = size;
		r.count   = count;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(r);
		sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [47:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic settle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain_heap();
		int j;
		j = sb.first_busy();
		while (j >= 0) begin
			send(KIND_FREE, 48'(64'(sb.st[j]) + HEADER_BYTES), $urandom, $urandom);
			j = sb.first_busy();
		end
	endtask

	function automatic logic [31:0] pick_size();
		int p;
		p = $urandom_range(99);
		if (p < 75)
			return $urandom_range(1, 512);
		if (p < 90)
			return $urandom_range(513, 65536);
		if (p < 95)
			return $urandom;
		if (p < 97)
			return 32'd0;
		return $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
	endfunction

	function automatic logic [47:0] pick_addr();
		int p;
		int j;
		p = $urandom_range(99);
		if (sb.used == 0 || p < 10)
			return 48'({$urandom, $urandom});
		j = $urandom_range(sb.used - 1);
		if (p < 18)
			return 48'(64'(sb.st[j]) + HEADER_BYTES + 16);
		return 48'(64'(sb.st[j]) + HEADER_BYTES);
	endfunction

	task automatic random_request();
		int p;
		p = $urandom_range(99);
		if (p < 35)
			send(KIND_MALLOC, 48'({$urandom, $urandom}), pick_size(), $urandom);
		else if (p < 60)
			send(KIND_FREE, pick_addr(), $urandom, $urandom);
		else if (p < 85)
			send(KIND_REALLOC, ($urandom_range(9) == 0) ? 48'd0 : pick_addr(),
				($urandom_range(19) == 0) ? 32'd0 : pick_size(), $urandom);
		else if (p < 95)
			send(KIND_CALLOC, 48'({$urandom, $urandom}), $urandom_range(0, 64),
				$urandom_range(0, 16));
		else
			send(KIND_CALLOC, 48'({$urandom, $urandom}), $urandom, $urandom);
	endtask

	task automatic directed();
		logic [47:0] a0, a1, a, b, c;
		send(KIND_MALLOC, 48'd0, 32'd0, 32'd0);
		send(KIND_MALLOC, 48'hFFFF_FFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
		a0 = sb.last_addr;
		send(KIND_MALLOC, 48'd0, 32'hFFFF_FFFF, 32'd0);
		send(KIND_MALLOC, 48'd0, 32'hFFFF_FFF1, 32'd0);
		send(KIND_CALLOC, 48'd0, 32'h0001_0000, 32'h0001_0000);
		send(KIND_CALLOC, 48'd0, 32'd0, 32'd7);
		send(KIND_CALLOC, 48'd0, 32'd3, 32'd5);
		a1 = sb.last_addr;
		send(KIND_FREE, 48'd0, 32'd0, 32'd0);
		send(KIND_FREE, 48'h12_3456, 32'd0, 32'd0);
		send(KIND_FREE, 48'hFFFF_FFFF_FFFF, 32'd0, 32'd0);
		send(KIND_MALLOC, 48'd0, 32'd100, 32'd0);
		a = sb.last_addr;
		send(KIND_MALLOC, 48'd0, 32'd200, 32'd0);
		b = sb.last_addr;
		send(KIND_MALLOC, 48'd0, 32'd50, 32'd0);
		c = sb.last_addr;
		send(KIND_FREE, a, 32'd0, 32'd0);
		send(KIND_FREE, a, 32'd0, 32'd0);
		send(KIND_REALLOC, 48'd0, 32'd64, 32'd0);
		send(KIND_REALLOC, b, 32'd16, 32'd0);
		send(KIND_REALLOC, b, 32'd150, 32'd0);
		send(KIND_REALLOC, b, 32'd5000, 32'd0);
		send(KIND_REALLOC, 48'hAB_CDE0, 32'd10, 32'd0);
		send(KIND_REALLOC, c, 32'd0, 32'd0);
		send(KIND_REALLOC, c, 32'd8, 32'd0);
		send(KIND_FREE, a1, 32'd0, 32'd0);
		send(KIND_FREE, a0, 32'd0, 32'd0);
	endtask

	logic [47:0] base_set[5];
	logic [47:0] limit_set[5];
	int          idle_set[5];

	initial begin
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_HEAP_BASE;
		cfg_data  = '0;
		cycles    = 0;
		sent      = 0;
		idle_pct  = 0;
		arst_n    = 1'b0;

		base_set  = '{48'h100, 48'h1000, 48'hFFFF_FFFF_F000, 48'h0, 48'h8000_0000_0000};
		limit_set = '{48'h10_0000, 48'h4000, 48'hFFFF_FFFF_FFFF, 48'h0,
			48'hFFFF_FFFF_FFFF};
		idle_set  = '{0, 86, 0, 6, 86};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 5; ph++) begin
			// odd phases keep the table, so the base write only moves the register
			if (ph % 2 == 0)
				drain_heap();
			settle();
			write_reg(CFG_HEAP_BASE, base_set[ph]);
			write_reg(CFG_HEAP_LIMIT, limit_set[ph]);
			idle_pct = idle_set[ph];
			if (ph == 0)
				directed();
			for (int n = 0; n < ((ph == 3) ? 120 : 420); n++) begin
				if (ph == 1 && n == 200)
					settle();
				random_request();
			end
		end
		// limit dropped below a live break only blocks growth
		settle();
		write_reg(CFG_HEAP_LIMIT, 48'h10);
		idle_pct = 0;
		for (int n = 0; n < 60; n++)
			random_request();
		drain_heap();

		settle();
		repeat (20) @(posedge clk);
		$display("tb: %0d requests sent, %0d responses checked, %0d mismatches",
			sent, sb.checked, sb.errors);
		$display("tb: covered heap base/limit extremes, table full, split, merge, moves");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/first_fit_heap_allocator_core.sv
test/tb.sv
